/* sv/wsh64_pkg.sv */
// shared constants and helpers for the 64-bit word stream hash
`default_nettype none

package wsh64_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3 = 64'h165667B19E3779F9;
    localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

    // rotate left, amount 1..63
    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

    // start value of one lane accumulator
    function automatic logic [63:0] lane_init(input logic [63:0] s, input logic [1:0] k);
        logic [63:0] v;
        case (k)
            2'd0:    v = s + P1 + P2;
            2'd1:    v = s + P2;
            2'd2:    v = s;
            default: v = s - P1;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/word_stream_hash64.sv */
// word_stream_hash64: hash of a stream of 64-bit words on four lane accumulators
//
// input channel: item_valid / item_stall with word, word_valid and last.
// a word is taken when item_valid is high and item_stall is low. word_valid
// low with last high closes the sequence without adding a word.
// output channel: hash_valid / hash_stall with hash_value, one hash per
// sequence. the result sits in an output register; while the receiver
// stalls it holds, and the block keeps taking words until it needs to
// write the next hash.
// seed channel: seed_valid / seed_ready, accepted only while idle.
// all 64-bit products run on one shared 32x32 multiplier, three partial
// products per multiply.
// sequencing: a word that only fills the stripe buffer leaves the block idle; a
// word that completes a stripe stalls the input for eight multiplies, two per lane.
// a closing item starts the finish once any stripe it completes is folded in:
// the base is seed + P5 with fewer than four words, else the lane sum, then one
// tail round per buffered leftover word and the avalanche; the next word can be
// taken in the same cycle as the hash appears.
// reset: seed is 0, lanes hold the seed-0 start values, buffer and count empty.
`default_nettype none

module word_stream_hash64
    import wsh64_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output      logic        item_stall,
    input  wire logic [63:0] word,
    input  wire logic        word_valid,
    input  wire logic        last,
    output      logic        hash_valid,
    input  wire logic        hash_stall,
    output      logic [63:0] hash_value,
    input  wire logic        seed_valid,
    output      logic        seed_ready,
    input  wire logic [63:0] seed
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_LANE_A   = 4'd1;
    localparam logic [3:0] ST_LANE_B   = 4'd2;
    localparam logic [3:0] ST_LANE_C   = 4'd3;
    localparam logic [3:0] ST_FIN_BASE = 4'd4;
    localparam logic [3:0] ST_FIN_LEN  = 4'd5;
    localparam logic [3:0] ST_FIN_SUM  = 4'd6;
    localparam logic [3:0] ST_TAIL_A   = 4'd7;
    localparam logic [3:0] ST_TAIL_B   = 4'd8;
    localparam logic [3:0] ST_TAIL_C   = 4'd9;
    localparam logic [3:0] ST_TAIL_D   = 4'd10;
    localparam logic [3:0] ST_AV_B     = 4'd11;
    localparam logic [3:0] ST_AV_C     = 4'd12;
    localparam logic [3:0] ST_MUL      = 4'd13;

    logic [3:0]             state_reg, state_next;
    logic [3:0]             ret_reg, ret_next;
    logic [1:0]             step_reg, step_next;
    logic [1:0]             idx_reg, idx_next;
    logic [1:0]             pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [63:0]            seed_reg, seed_next;
    logic [63:0]            lane_reg [4];
    logic [63:0]            lane_next [4];
    logic                   last_reg, last_next;
    logic                   hash_valid_reg, hash_valid_next;

    logic [63:0]            pend_reg [3];
    logic [63:0]            pend_next [3];
    logic [63:0]            word_reg, word_next;
    logic [63:0]            h_reg, h_next;
    logic [63:0]            mul_a_reg, mul_a_next;
    logic [63:0]            mul_b_reg, mul_b_next;
    logic [63:0]            acc_reg, acc_next;
    logic [63:0]            prod_reg, prod_next;
    logic [63:0]            hash_value_reg, hash_value_next;

    logic                   in_take;
    logic                   seed_take;
    logic                   big;
    logic [63:0]            len_term;
    logic [63:0]            pend_rd;
    logic [63:0]            lane_rd;
    logic [63:0]            lane_word;
    logic [63:0]            lane_rot;
    logic [31:0]            mul_x, mul_y;
    logic [63:0]            mul_p;

    assign item_stall = (state_reg != ST_IDLE);
    assign seed_ready = (state_reg == ST_IDLE) && !item_valid;
    assign hash_valid = hash_valid_reg;
    assign hash_value = hash_value_reg;

    assign in_take   = item_valid && !item_stall;
    assign seed_take = seed_valid && seed_ready;
    assign big       = count_reg > COUNT_WIDTH'(3);
    assign len_term  = 64'(count_reg) << 3;
    assign lane_rd   = lane_reg[idx_reg];

    always_comb
    begin
        case (idx_reg)
            2'd0:    pend_rd = pend_reg[0];
            2'd1:    pend_rd = pend_reg[1];
            default: pend_rd = pend_reg[2];
        endcase
    end

    assign lane_word = (idx_reg == 2'd3) ? word_reg : pend_rd;

    always_comb
    begin
        case (idx_reg)
            2'd0:    lane_rot = rotl64(lane_rd, 1);
            2'd1:    lane_rot = rotl64(lane_rd, 7);
            2'd2:    lane_rot = rotl64(lane_rd, 12);
            default: lane_rot = rotl64(lane_rd, 18);
        endcase
    end

    // low 64 bits of a*b from lo*lo, hi*lo and lo*hi
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mul_x = mul_a_reg[31:0];
                mul_y = mul_b_reg[31:0];
            end
            2'd1:
            begin
                mul_x = mul_a_reg[63:32];
                mul_y = mul_b_reg[31:0];
            end
            default:
            begin
                mul_x = mul_a_reg[31:0];
                mul_y = mul_b_reg[63:32];
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        step_next       = step_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        seed_next       = seed_reg;
        last_next       = last_reg;
        hash_valid_next = hash_valid_reg && hash_stall;
        word_next       = word_reg;
        h_next          = h_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        hash_value_next = hash_value_reg;
        for (int i = 0; i < 4; i++)
        begin
            lane_next[i] = lane_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            pend_next[i] = pend_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (seed_take)
                begin
                    seed_next = seed;
                    if (count_reg == '0 && pos_reg == 2'd0)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            lane_next[i] = lane_init(seed, 2'(i));
                        end
                    end
                end
                if (in_take)
                begin
                    word_next = word;
                    last_next = last;
                    if (word_valid)
                    begin
                        count_next = count_reg + COUNT_WIDTH'(1);
                    end
                    if (word_valid && pos_reg == 2'd3)
                    begin
                        idx_next   = 2'd0;
                        state_next = ST_LANE_A;
                    end
                    else
                    begin
                        if (word_valid)
                        begin
                            pend_next[pos_reg] = word;
                            pos_next = pos_reg + 2'd1;
                        end
                        if (last)
                        begin
                            state_next = ST_FIN_BASE;
                        end
                    end
                end
            end
            ST_LANE_A:
            begin
                mul_a_next = lane_word;
                mul_b_next = P2;
                ret_next   = ST_LANE_B;
                step_next  = 2'd0;
                state_next = ST_MUL;
            end
            ST_LANE_B:
            begin
                mul_a_next = rotl64(lane_rd + acc_reg, 31);
                mul_b_next = P1;
                ret_next   = ST_LANE_C;
                step_next  = 2'd0;
                state_next = ST_MUL;
            end
            ST_LANE_C:
            begin
                lane_next[idx_reg] = acc_reg;
                if (idx_reg == 2'd3)
                begin
                    pos_next   = 2'd0;
                    state_next = last_reg ? ST_FIN_BASE : ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_LANE_A;
                end
            end
            ST_FIN_BASE:
            begin
                idx_next = 2'd0;
                if (big)
                begin
                    h_next     = len_term;
                    state_next = ST_FIN_SUM;
                end
                else
                begin
                    h_next     = P5 + seed_reg;
                    state_next = ST_FIN_LEN;
                end
            end
            ST_FIN_LEN:
            begin
                h_next     = h_reg + len_term;
                idx_next   = 2'd0;
                state_next = ST_TAIL_A;
            end
            ST_FIN_SUM:
            begin
                h_next = h_reg + lane_rot;
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_TAIL_A;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            ST_TAIL_A:
            begin
                step_next  = 2'd0;
                state_next = ST_MUL;
                if (idx_reg < pos_reg)
                begin
                    mul_a_next = pend_rd;
                    mul_b_next = P2;
                    ret_next   = ST_TAIL_B;
                end
                else
                begin
                    // first avalanche round
                    mul_a_next = h_reg ^ (h_reg >> 33);
                    mul_b_next = P2;
                    ret_next   = ST_AV_B;
                end
            end
            ST_TAIL_B:
            begin
                mul_a_next = rotl64(acc_reg, 31);
                mul_b_next = P1;
                ret_next   = ST_TAIL_C;
                step_next  = 2'd0;
                state_next = ST_MUL;
            end
            ST_TAIL_C:
            begin
                mul_a_next = rotl64(h_reg ^ acc_reg, 27);
                mul_b_next = P1;
                ret_next   = ST_TAIL_D;
                step_next  = 2'd0;
                state_next = ST_MUL;
            end
            ST_TAIL_D:
            begin
                h_next     = acc_reg + P4;
                idx_next   = idx_reg + 2'd1;
                state_next = ST_TAIL_A;
            end
            ST_AV_B:
            begin
                mul_a_next = acc_reg ^ (acc_reg >> 29);
                mul_b_next = P3;
                ret_next   = ST_AV_C;
                step_next  = 2'd0;
                state_next = ST_MUL;
            end
            ST_AV_C:
            begin
                // wait until the previous hash has left the output register
                if (!(hash_valid_reg && hash_stall))
                begin
                    hash_valid_next = 1'b1;
                    hash_value_next = acc_reg ^ (acc_reg >> 32);
                    pos_next        = 2'd0;
                    count_next      = '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        lane_next[i] = lane_init(seed_reg, 2'(i));
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                prod_next = mul_p;
                step_next = step_reg + 2'd1;
                case (step_reg)
                    2'd0:
                    begin
                        acc_next = acc_reg;
                    end
                    2'd1:
                    begin
                        acc_next = prod_reg;
                    end
                    2'd2:
                    begin
                        acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                    end
                    default:
                    begin
                        acc_next   = acc_reg + {prod_reg[31:0], 32'd0};
                        state_next = ret_reg;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            step_reg       <= 2'd0;
            idx_reg        <= 2'd0;
            pos_reg        <= 2'd0;
            count_reg      <= '0;
            seed_reg       <= 64'd0;
            last_reg       <= 1'b0;
            hash_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                lane_reg[i] <= lane_init(64'd0, 2'(i));
            end
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            step_reg       <= step_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            seed_reg       <= seed_next;
            last_reg       <= last_next;
            hash_valid_reg <= hash_valid_next;
            for (int i = 0; i < 4; i++)
            begin
                lane_reg[i] <= lane_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        h_reg          <= h_next;
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        hash_value_reg <= hash_value_next;
        for (int i = 0; i < 3; i++)
        begin
            pend_reg[i] <= pend_next[i];
        end
    end

    // a closing word always keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && last) |=> item_stall)
        else $error("closing word did not start the finish sequence");

    // a new hash only appears out of the final avalanche step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid) |-> $past(state_reg == ST_AV_C))
        else $error("hash_valid rose outside the avalanche step");

    // the multiplier always returns into a consumer state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (ret_reg != ST_MUL && ret_reg != ST_IDLE))
        else $error("multiplier return state is invalid");

    // seed writes and word accepts never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (seed_valid && seed_ready) |-> !(item_valid && !item_stall))
        else $error("seed write collided with a word accept");

endmodule

`default_nettype wire

/* bench/tb.sv */
// testbench for word_stream_hash64: directed table and random word sequences checked by a predictor
`timescale 1ns / 100ps

module tb
    import wsh64_pkg::*;
();

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 140;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [63:0] data;
        bit          has_word;
        bit          closes;
        bit          typed;
        logic [63:0] want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [63:0] word = 64'd0;
    logic        word_valid = 1'b0;
    logic        last = 1'b0;
    logic        hash_valid;
    logic        hash_stall = 1'b0;
    logic [63:0] hash_value;
    logic        seed_valid = 1'b0;
    logic        seed_ready;
    logic [63:0] seed = 64'd0;

    // hash state mirrored from the block
    logic [63:0] seed_now;
    logic [63:0] lane_acc [4];
    logic [63:0] stripe_buf [3];
    int unsigned stripe_pos;
    logic [31:0] words_taken;

    logic [63:0] expected_hashes [$];
    logic [63:0] want_hash;
    int          errors = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    logic [63:0] phase_seeds [PHASES];

    stim_row_t directed_rows [20] = '{
        // empty sequence right after reset, seed 0
        '{64'h0, 1'b0, 1'b1, 1'b1, 64'hEF46DB3751D8E999},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 64'h0},
        '{64'h0, 1'b1, 1'b1, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 64'h0},
        // exactly one stripe
        '{64'h0, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'h0000_0000_0000_0001, 1'b1, 1'b1, 1'b0, 64'h0},
        // seven words, an idle item inside, closed without data
        '{64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b0, 1'b0, 64'h0},
        '{64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'h0, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'h8000_0000_0000_0001, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'h1234_5678_9ABC_DEF0, 1'b0, 1'b1, 1'b0, 64'h0},
        // three words, all left in the stripe buffer
        '{64'hFFFF_FFFF_0000_0000, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 64'h0},
        '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 64'h0}
    };

    word_stream_hash64 DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .word       (word),
        .word_valid (word_valid),
        .last       (last),
        .hash_valid (hash_valid),
        .hash_stall (hash_stall),
        .hash_value (hash_value),
        .seed_valid (seed_valid),
        .seed_ready (seed_ready),
        .seed       (seed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rot_left(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

    function automatic logic [63:0] mix_word(input logic [63:0] acc, input logic [63:0] w);
        return rot_left(acc + w * P2, 31) * P1;
    endfunction

    task automatic reload_lanes();
        lane_acc[0] = seed_now + P1 + P2;
        lane_acc[1] = seed_now + P2;
        lane_acc[2] = seed_now;
        lane_acc[3] = seed_now - P1;
    endtask

    task automatic apply_seed(input logic [63:0] v);
        seed_now = v;
        if (words_taken == 0 && stripe_pos == 0)
            reload_lanes();
    endtask

    // advance the mirrored state by one item; closes is set when a hash comes out
    task automatic take_item(input logic [63:0] w, input bit has_word, input bit lst,
                             output bit closes, output logic [63:0] h);
        if (has_word)
        begin
            if (stripe_pos < 3)
            begin
                stripe_buf[stripe_pos] = w;
                stripe_pos++;
            end
            else
            begin
                lane_acc[0] = mix_word(lane_acc[0], stripe_buf[0]);
                lane_acc[1] = mix_word(lane_acc[1], stripe_buf[1]);
                lane_acc[2] = mix_word(lane_acc[2], stripe_buf[2]);
                lane_acc[3] = mix_word(lane_acc[3], w);
                stripe_pos = 0;
            end
            words_taken = words_taken + 32'd1;
        end
        closes = lst;
        h = 64'd0;
        if (lst)
        begin
            if (words_taken >= 4)
                h = rot_left(lane_acc[0], 1) + rot_left(lane_acc[1], 7)
                  + rot_left(lane_acc[2], 12) + rot_left(lane_acc[3], 18);
            else
                h = P5 + seed_now;
            h = h + 64'(words_taken) * 64'd8;
            for (int i = 0; i < stripe_pos; i++)
                h = rot_left(h ^ mix_word(64'd0, stripe_buf[i]), 27) * P1 + P4;
            h = h ^ (h >> 33);
            h = h * P2;
            h = h ^ (h >> 29);
            h = h * P3;
            h = h ^ (h >> 32);
            reload_lanes();
            stripe_pos = 0;
            words_taken = 32'd0;
        end
    endtask

    task automatic set_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 45; stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 45; end
            default:       begin sender_idle_pct = 30; stall_pct = 30; end
        endcase
    endtask

    function automatic logic [63:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 64'd0;
        if (pick == 1)
            return 64'hFFFF_FFFF_FFFF_FFFF;
        return {$urandom, $urandom};
    endfunction

    // starts and ends just after a falling edge
    task automatic send_item(input logic [63:0] w, input bit has_word, input bit lst,
                             input bit typed, input logic [63:0] want);
        bit          closes;
        logic [63:0] h;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        word       <= w;
        word_valid <= has_word;
        last       <= lst;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        take_item(w, has_word, lst, closes, h);
        if (closes)
            expected_hashes.push_back(typed ? want : h);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        while (expected_hashes.size() != 0)
            @(posedge clk);
        // a stripe word may still be in the multiplier
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        seed_valid <= 1'b1;
        seed       <= v;
        do
            @(posedge clk);
        while (seed_ready !== 1'b1);
        apply_seed(v);
        @(negedge clk);
        seed_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input bit dangle);
        int sent;
        int len;
        int unsigned pick;
        bit close_sep;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                len = 0;
            else if (pick < 70)
                len = $urandom_range(8, 1);
            else if (pick < 92)
                len = $urandom_range(24, 9);
            else
                len = $urandom_range(60, 25);
            close_sep = (len == 0) || ($urandom_range(3) == 0);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(19) == 0)
                    send_item(rand_word(), 1'b0, 1'b0, 1'b0, 64'd0);
                send_item(rand_word(), 1'b1, !close_sep && k == len - 1, 1'b0, 64'd0);
            end
            if (close_sep)
                send_item(rand_word(), 1'b0, 1'b1, 1'b0, 64'd0);
            sent += len + int'(close_sep);
        end
        // leave a sequence open across the next seed write
        if (dangle)
            repeat ($urandom_range(6, 1)) send_item(rand_word(), 1'b1, 1'b0, 1'b0, 64'd0);
    endtask

    always @(negedge clk)
        hash_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && hash_valid === 1'b1 && hash_stall == 1'b0)
        begin
            if (expected_hashes.size() == 0)
            begin
                $display("%0t: unexpected hash, expected none, got %h", $time, hash_value);
                errors++;
            end
            else
            begin
                want_hash = expected_hashes.pop_front();
                if (hash_value !== want_hash)
                begin
                    $display("%0t: hash mismatch, expected %h, got %h",
                             $time, want_hash, hash_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d hashes still awaited", $time, expected_hashes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        seed_now = 64'd0;
        stripe_pos = 0;
        words_taken = 32'd0;
        reload_lanes();
        phase_seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        phase_seeds[1] = {$urandom, $urandom};
        phase_seeds[2] = 64'd0;
        phase_seeds[3] = 64'd1;
        phase_seeds[4] = 64'h8000_0000_0000_0000;
        // short-input base becomes zero
        phase_seeds[5] = 64'd0 - P5;
        phase_seeds[6] = {$urandom, $urandom};
        phase_seeds[7] = {$urandom, $urandom};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_mode(IDLE_NONE);
        foreach (directed_rows[i])
            send_item(directed_rows[i].data, directed_rows[i].has_word, directed_rows[i].closes,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            item_valid <= 1'b0;
            wait_for_drain();
            write_seed(phase_seeds[p]);
            set_mode(idle_mode_t'(p % 4));
            run_phase(PHASE_ITEMS, p[0]);
        end

        item_valid <= 1'b0;
        wait_for_drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
sv/wsh64_pkg.sv
sv/word_stream_hash64.sv
bench/tb.sv
